[rtl/sit_pkg.sv]
// ----------------------------------------------------------------------------
// sit_pkg: shared types for the segment intersection test
// Widths of coordinates, differences and cross products, and the beat
// structures handed from one pipeline stage to the next.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int CROSS_BITS = PROD_BITS + 1;

	// endpoint tests: index of the point checked against the other segment
	localparam int NPTS   = 4;
	localparam int PT_A2  = 0;  // second start against first segment
	localparam int PT_B2  = 1;  // second end against first segment
	localparam int PT_A1  = 2;  // first start against second segment
	localparam int PT_B1  = 3;  // first end against second segment

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [CROSS_BITS-1:0] cross_t;

	// stage 1 beat: direction vectors, point offsets, box flags
	typedef struct packed {
		diff_t              dir1_x;
		diff_t              dir1_y;
		diff_t              dir2_x;
		diff_t              dir2_y;
		diff_t [NPTS-1:0]   rel_x;
		diff_t [NPTS-1:0]   rel_y;
		logic  [NPTS-1:0]   in_box;
		logic               deg1;
		logic               deg2;
	} s1_t;

	// stage 2 beat: partial products of the cross products
	typedef struct packed {
		prod_t [NPTS-1:0]   pa;
		prod_t [NPTS-1:0]   pb;
		prod_t              da;
		prod_t              db;
		logic  [NPTS-1:0]   in_box;
		logic               deg1;
		logic               deg2;
	} s2_t;

	// stage 3 beat: sign flags of the cross products
	typedef struct packed {
		logic  [NPTS-1:0]   neg;
		logic  [NPTS-1:0]   zero;
		logic  [NPTS-1:0]   in_box;
		logic               coin;
	} s3_t;

	// point inside the closed bounding box of a segment
	function automatic logic in_box(
		input coord_t p_x, input coord_t p_y,
		input coord_t s_x, input coord_t s_y,
		input coord_t e_x, input coord_t e_y
	);
		logic ok_x;
		logic ok_y;
		ok_x = ((s_x <= p_x) && (p_x <= e_x)) || ((e_x <= p_x) && (p_x <= s_x));
		ok_y = ((s_y <= p_y) && (p_y <= e_y)) || ((e_y <= p_y) && (p_y <= s_y));
		return ok_x && ok_y;
	endfunction

endpackage

`default_nettype wire

[rtl/sit_diff.sv]
// ----------------------------------------------------------------------------
// sit_diff: pipeline stage 1
// Forms direction vectors and point offsets, and the bounding box and point-segment flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_diff (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  valid,
	input  sit_pkg::coord_t      first_a_x,
	input  sit_pkg::coord_t      first_a_y,
	input  sit_pkg::coord_t      first_b_x,
	input  sit_pkg::coord_t      first_b_y,
	input  sit_pkg::coord_t      second_a_x,
	input  sit_pkg::coord_t      second_a_y,
	input  sit_pkg::coord_t      second_b_x,
	input  sit_pkg::coord_t      second_b_y,
	output logic                 valid_s1,
	output sit_pkg::s1_t         data_s1
);

	sit_pkg::diff_t a1x, a1y, b1x, b1y, a2x, a2y, b2x, b2y;
	sit_pkg::s1_t   nxt;

	// widen coordinates so differences stay exact
	assign a1x = sit_pkg::diff_t'(first_a_x);
	assign a1y = sit_pkg::diff_t'(first_a_y);
	assign b1x = sit_pkg::diff_t'(first_b_x);
	assign b1y = sit_pkg::diff_t'(first_b_y);
	assign a2x = sit_pkg::diff_t'(second_a_x);
	assign a2y = sit_pkg::diff_t'(second_a_y);
	assign b2x = sit_pkg::diff_t'(second_b_x);
	assign b2y = sit_pkg::diff_t'(second_b_y);

	// direction vectors, offsets of each endpoint from the start of the other segment, and box flags
	always_comb begin
		nxt.dir1_x = b1x - a1x;
		nxt.dir1_y = b1y - a1y;
		nxt.dir2_x = b2x - a2x;
		nxt.dir2_y = b2y - a2y;
		nxt.rel_x[sit_pkg::PT_A2] = a2x - a1x;
		nxt.rel_y[sit_pkg::PT_A2] = a2y - a1y;
		nxt.rel_x[sit_pkg::PT_B2] = b2x - a1x;
		nxt.rel_y[sit_pkg::PT_B2] = b2y - a1y;
		nxt.rel_x[sit_pkg::PT_A1] = a1x - a2x;
		nxt.rel_y[sit_pkg::PT_A1] = a1y - a2y;
		nxt.rel_x[sit_pkg::PT_B1] = b1x - a2x;
		nxt.rel_y[sit_pkg::PT_B1] = b1y - a2y;
		nxt.in_box[sit_pkg::PT_A2] = sit_pkg::in_box(second_a_x, second_a_y,
			first_a_x, first_a_y, first_b_x, first_b_y);
		nxt.in_box[sit_pkg::PT_B2] = sit_pkg::in_box(second_b_x, second_b_y,
			first_a_x, first_a_y, first_b_x, first_b_y);
		nxt.in_box[sit_pkg::PT_A1] = sit_pkg::in_box(first_a_x, first_a_y,
			second_a_x, second_a_y, second_b_x, second_b_y);
		nxt.in_box[sit_pkg::PT_B1] = sit_pkg::in_box(first_b_x, first_b_y,
			second_a_x, second_a_y, second_b_x, second_b_y);
		// point segments
		nxt.deg1 = (first_a_x == first_b_x) && (first_a_y == first_b_y);
		nxt.deg2 = (second_a_x == second_b_x) && (second_a_y == second_b_y);
	end

	// advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	// capture payload
	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

endmodule

`default_nettype wire

[rtl/sit_mult.sv]
// ----------------------------------------------------------------------------
// sit_mult: pipeline stage 2
// Multiplies out the partial products of all cross products.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_mult (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  valid_s1,
	input  sit_pkg::s1_t         data_s1,
	output logic                 valid_s2,
	output sit_pkg::s2_t         data_s2
);

	sit_pkg::diff_t dir_x [sit_pkg::NPTS];
	sit_pkg::diff_t dir_y [sit_pkg::NPTS];
	sit_pkg::s2_t   nxt;

	// pick the direction of the segment each point is tested against
	always_comb begin
		for (int i = 0; i < sit_pkg::NPTS; i++) begin
			if (i < sit_pkg::PT_A1) begin
				dir_x[i] = data_s1.dir1_x;
				dir_y[i] = data_s1.dir1_y;
			end else begin
				dir_x[i] = data_s1.dir2_x;
				dir_y[i] = data_s1.dir2_y;
			end
		end
	end

	// one multiplier per partial product, all in parallel
	always_comb begin
		for (int i = 0; i < sit_pkg::NPTS; i++) begin
			nxt.pa[i] = sit_pkg::prod_t'(dir_x[i]) *
				sit_pkg::prod_t'($signed(data_s1.rel_y[i]));
			nxt.pb[i] = sit_pkg::prod_t'(dir_y[i]) *
				sit_pkg::prod_t'($signed(data_s1.rel_x[i]));
		end
		nxt.da     = sit_pkg::prod_t'(data_s1.dir1_x) * sit_pkg::prod_t'(data_s1.dir2_y);
		nxt.db     = sit_pkg::prod_t'(data_s1.dir1_y) * sit_pkg::prod_t'(data_s1.dir2_x);
		nxt.in_box = data_s1.in_box;
		nxt.deg1   = data_s1.deg1;
		nxt.deg2   = data_s1.deg2;
	end

	// advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// capture payload
	always_ff @(posedge clk) begin
		data_s2 <= nxt;
	end

endmodule

`default_nettype wire

[rtl/sit_sign.sv]
// ----------------------------------------------------------------------------
// sit_sign: pipeline stage 3
// Finishes the cross products and reduces them to sign and zero flags,
// and decides whether both segments lie on one common line.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_sign (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  valid_s2,
	input  sit_pkg::s2_t         data_s2,
	output logic                 valid_s3,
	output sit_pkg::s3_t         data_s3
);

	sit_pkg::cross_t cr [sit_pkg::NPTS];
	sit_pkg::cross_t det;
	sit_pkg::s3_t    nxt;

	// subtract partial products and classify
	always_comb begin
		for (int i = 0; i < sit_pkg::NPTS; i++) begin
			cr[i] = sit_pkg::cross_t'($signed(data_s2.pa[i])) -
				sit_pkg::cross_t'($signed(data_s2.pb[i]));
			nxt.neg[i]  = cr[i][sit_pkg::CROSS_BITS-1];
			nxt.zero[i] = (cr[i] == '0);
		end
		det = sit_pkg::cross_t'(data_s2.da) - sit_pkg::cross_t'(data_s2.db);
		nxt.in_box = data_s2.in_box;
		// common line: a point segment, or parallel with a shared point
		nxt.coin = data_s2.deg1 || data_s2.deg2 ||
			((det == '0) && (cr[sit_pkg::PT_A2] == '0));
	end

	// advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	// capture payload
	always_ff @(posedge clk) begin
		data_s3 <= nxt;
	end

endmodule

`default_nettype wire

[rtl/segment_intersection_test.sv]
// ----------------------------------------------------------------------------
// segment_intersection_test: closed 2-D segment intersection test
// Four-stage pipeline: offsets and boxes, products, signs, decision.
//
// Usage:
//  - Present both segments' endpoints on the coordinate ports and raise
//    start. A beat is taken at each rising edge with start high and busy
//    low. busy stays low, so one beat can be taken every cycle.
//  - Each beat gives one result: intersects is valid while done is high,
//    for exactly one cycle, after the beat has passed the register after
//    each of difference, multiply, sign and decision.
//  - Throughput is one beat per cycle.
//  - Results leave in the order the beats came in. The receiver cannot
//    stall; it must take each result in its done cycle.
//  - Reset clears all valid bits, so no result is given for beats in
//    flight when reset is asserted.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_test (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  sit_pkg::coord_t      first_a_x,
	input  sit_pkg::coord_t      first_a_y,
	input  sit_pkg::coord_t      first_b_x,
	input  sit_pkg::coord_t      first_b_y,
	input  sit_pkg::coord_t      second_a_x,
	input  sit_pkg::coord_t      second_a_y,
	input  sit_pkg::coord_t      second_b_x,
	input  sit_pkg::coord_t      second_b_y,
	output logic                 done,
	output logic                 intersects
);

	logic                     valid_s1, valid_s2, valid_s3;
	sit_pkg::s1_t             data_s1;
	sit_pkg::s2_t             data_s2;
	sit_pkg::s3_t             data_s3;
	logic [sit_pkg::NPTS-1:0] on_seg;
	logic                     le0 [sit_pkg::NPTS];
	logic                     ge0 [sit_pkg::NPTS];
	logic                     str1, str2, hit;

	// pipeline never stalls
	assign busy = 1'b0;

	sit_diff u_diff (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (start && !busy),
		.first_a_x  (first_a_x),
		.first_a_y  (first_a_y),
		.first_b_x  (first_b_x),
		.first_b_y  (first_b_y),
		.second_a_x (second_a_x),
		.second_a_y (second_a_y),
		.second_b_x (second_b_x),
		.second_b_y (second_b_y),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	sit_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	sit_sign u_sign (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	// decide: endpoint on segment for common lines, straddle test otherwise
	always_comb begin
		for (int i = 0; i < sit_pkg::NPTS; i++) begin
			le0[i] = data_s3.neg[i] || data_s3.zero[i];
			ge0[i] = !data_s3.neg[i];
		end
		on_seg = data_s3.zero & data_s3.in_box;
		str1 = (le0[sit_pkg::PT_A2] && ge0[sit_pkg::PT_B2]) ||
			(ge0[sit_pkg::PT_A2] && le0[sit_pkg::PT_B2]);
		str2 = (le0[sit_pkg::PT_A1] && ge0[sit_pkg::PT_B1]) ||
			(ge0[sit_pkg::PT_A1] && le0[sit_pkg::PT_B1]);
		hit = data_s3.coin ? (|on_seg) : (str1 && str2);
	end

	// advance result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s3;
		end
	end

	// register result flag
	always_ff @(posedge clk) begin
		intersects <= hit;
	end

	// every result stems from a matching beat on start
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result without a matching beat");

	// a shared start point always intersects
	a_shared_pt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past((first_a_x == second_a_x) && (first_a_y == second_a_y), 4))
		|-> intersects)
		else $error("shared endpoint not reported");

	// a first segment wholly left of the second in x never intersects
	a_apart_x: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past((first_a_x < second_a_x) && (first_a_x < second_b_x) &&
			(first_b_x < second_a_x) && (first_b_x < second_b_x), 4))
		|-> !intersects)
		else $error("disjoint x ranges reported as intersecting");

endmodule

`default_nettype wire
